### rtl/clre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clre_pkg
// Shared types and constants for the character LCD refresh engine.
// ----------------------------------------------------------------------------
package clre_pkg;

    localparam int unsigned BUF_DEPTH = 32;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned NIB_W     = 4;

    localparam logic [CHAR_W-1:0] CMD_SET_ADDR = 8'h80;
    localparam logic [CHAR_W-1:0] ROW_OFFSET   = 8'h40;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] character;
    } t_in_word;

    typedef struct packed {
        logic             reg_select;
        logic             enable;
        logic [NIB_W-1:0] data_nibble;
    } t_out_word;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] addr;
    } t_fetch;

endpackage

### rtl/clre_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clre_buffer
// Screen buffer: 32 character registers, written by store words and read
// by the refresh sequencer. Zero codes and misses read back as space.
// ----------------------------------------------------------------------------
module clre_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [clre_pkg::POS_W-1:0]    i_wr_addr,
    input  logic [clre_pkg::CHAR_W-1:0]   i_wr_data,
    input  clre_pkg::t_fetch              i_fetch,
    output logic [clre_pkg::CHAR_W-1:0]   o_fetch_char
);
    import clre_pkg::*;

    logic [CHAR_W-1:0] r_mem [BUF_DEPTH];
    logic [CHAR_W-1:0] raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUF_DEPTH; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_comb begin
        raw          = i_fetch.hit ? r_mem[i_fetch.addr] : '0;
        o_fetch_char = (raw == '0) ? SPACE_CODE : raw;
    end

endmodule

### rtl/clre_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clre_seq
// Four-phase bus sequencer: pin levels, column and row counters, and the
// byte staged for the next transfer.
// ----------------------------------------------------------------------------
module clre_seq #(
    parameter int unsigned COLUMNS = 16,
    parameter int unsigned ROWS    = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic [clre_pkg::CHAR_W-1:0]   i_fetch_char,
    output clre_pkg::t_fetch              o_fetch,
    output clre_pkg::t_out_word           o_pins_next
);
    import clre_pkg::*;

    localparam int unsigned COL_W = $clog2(COLUMNS + 1);
    localparam int unsigned IDX_W = $clog2(ROWS * COLUMNS + 1);

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_HIGH_E,
        PH_LOW,
        PH_LOW_E
    } t_phase;

    t_phase            r_phase,     n_phase;
    logic [COL_W-1:0]  r_col,       n_col;
    logic              r_row,       n_row;
    logic              r_pend_rs,   n_pend_rs;
    logic [CHAR_W-1:0] r_pend_byte, n_pend_byte;
    t_out_word         r_pins,      n_pins;
    logic [IDX_W-1:0]  idx;

    // buffer index of the character at the current column
    always_comb begin
        idx = IDX_W'(r_col) + IDX_W'(32'(r_row) * COLUMNS);
        o_fetch.hit  = 32'(idx) < BUF_DEPTH;
        o_fetch.addr = POS_W'(idx);
    end

    always_comb begin
        n_phase     = r_phase;
        n_col       = r_col;
        n_row       = r_row;
        n_pend_rs   = r_pend_rs;
        n_pend_byte = r_pend_byte;
        n_pins      = r_pins;
        case (r_phase)
            PH_HIGH: begin
                n_pins.reg_select  = r_pend_rs;
                n_pins.enable      = 1'b0;
                n_pins.data_nibble = r_pend_byte[CHAR_W-1 -: NIB_W];
                n_phase            = PH_HIGH_E;
            end
            PH_HIGH_E: begin
                n_pins.enable = 1'b1;
                n_phase       = PH_LOW;
            end
            PH_LOW: begin
                n_pins.enable      = 1'b0;
                n_pins.data_nibble = r_pend_byte[NIB_W-1:0];
                n_phase            = PH_LOW_E;
            end
            PH_LOW_E: begin
                n_pins.enable = 1'b1;
                n_phase       = PH_HIGH;
                if (32'(r_col) == COLUMNS) begin
                    // end of row: jump to start of next row
                    n_col       = '0;
                    n_row       = (32'(r_row) + 1 > ROWS - 1) ? 1'b0 : 1'b1;
                    n_pend_byte = n_row ? (CMD_SET_ADDR | ROW_OFFSET) : CMD_SET_ADDR;
                    n_pend_rs   = 1'b0;
                end else begin
                    n_col       = r_col + 1'b1;
                    n_pend_byte = i_fetch_char;
                    n_pend_rs   = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HIGH;
            end
        endcase
    end

    assign o_pins_next = n_pins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HIGH;
            r_col       <= '0;
            r_row       <= 1'b0;
            r_pend_rs   <= 1'b0;
            r_pend_byte <= CMD_SET_ADDR;
            r_pins      <= '0;
        end else if (i_tick) begin
            r_phase     <= n_phase;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pend_rs   <= n_pend_rs;
            r_pend_byte <= n_pend_byte;
            r_pins      <= n_pins;
        end
    end

endmodule

### rtl/char_lcd_refresh_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_refresh_engine
// Refreshes a character LCD over a 4-bit bus from a local screen buffer,
// one bus phase per tick word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes words of two
//   kinds. A store word (op = 1) writes a character code into the screen
//   buffer at 'position' and returns nothing. A tick word (op = 0) advances
//   the bus by one phase and returns one output word with the RS, E and
//   D7..D4 levels after that phase.
//   Output channel (o_out_valid / i_out_ready / o_out_word) carries those
//   pin levels in order.
//   A word is registered at acceptance; a tick word's result is loaded
//   into the output register once that register is free, raising
//   o_out_valid. Throughput is one word per cycle unless the output
//   stalls, set by the single stage between the input and output registers.
//   Reset (i_rst_n low, synchronous) clears the buffer to zero, returns the
//   bus to phase 0 with the row 0 set-address command staged, and empties
//   both registers.
//   When the receiver stalls, the output register holds its word; one more
//   word is held in the input register, then o_in_ready drops. Store words
//   still drain past a stalled output.
// ----------------------------------------------------------------------------
module char_lcd_refresh_engine #(
    parameter int unsigned COLUMNS = 16,
    parameter int unsigned ROWS    = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  clre_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output clre_pkg::t_out_word  o_out_word
);
    import clre_pkg::*;

    logic        r_in_valid;
    t_in_word    r_in_word;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        is_tick;
    logic        out_free;
    logic        s1_adv;
    logic        tick_en;
    logic        wr_en;
    t_fetch      fetch;
    logic [CHAR_W-1:0] fetch_char;
    t_out_word   pins_next;

    assign is_tick    = (r_in_word.op == OP_TICK);
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_in_valid && (!is_tick || out_free);
    assign tick_en    = s1_adv && is_tick;
    assign wr_en      = s1_adv && (r_in_word.op == OP_WRITE);
    assign o_in_ready = !r_in_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_en) begin
            r_out_word <= pins_next;
        end
    end

    clre_buffer u_buffer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (r_in_word.position),
        .i_wr_data    (r_in_word.character),
        .i_fetch      (fetch),
        .o_fetch_char (fetch_char)
    );

    clre_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_en),
        .i_fetch_char (fetch_char),
        .o_fetch      (fetch),
        .o_pins_next  (pins_next)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### dv/char_lcd_refresh_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_refresh_engine_checker
// Watches both channels of the LCD refresh engine. Keeps its own copy of the
// bus sequencer and screen buffer. Predicts the pin levels for each tick word
// and compares every returned word, field by field, in order.
// ----------------------------------------------------------------------------
module char_lcd_refresh_engine_checker #(
    parameter int unsigned COLUMNS = 16,
    parameter int unsigned ROWS    = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  clre_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  clre_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_outstanding,
    output int                  o_tick_words,
    output int                  o_store_words,
    output int                  o_checked_words
);
    import clre_pkg::*;

    typedef enum logic [1:0] {
        PH_HIGH_SETUP  = 2'd0,
        PH_HIGH_STROBE = 2'd1,
        PH_LOW_SETUP   = 2'd2,
        PH_LOW_STROBE  = 2'd3
    } lcd_phase_e;

    lcd_phase_e       bus_phase;
    int               col_cnt;
    int               row_idx;
    logic             next_rs;
    logic [CHAR_W-1:0] next_byte;
    t_out_word        pins;
    logic [CHAR_W-1:0] shadow_buf [BUF_DEPTH];
    t_out_word        pin_queue [$];

    initial begin
        o_fail_count    = 0;
        o_outstanding   = 0;
        o_tick_words    = 0;
        o_store_words   = 0;
        o_checked_words = 0;
    end

    function automatic logic [CHAR_W-1:0] shown_char(int idx);
        logic [CHAR_W-1:0] c;
        c = '0;
        if (idx >= 0 && idx < BUF_DEPTH) begin
            c = shadow_buf[idx];
        end
        return (c == '0) ? SPACE_CODE : c;
    endfunction

    task automatic stage_next_byte();
        col_cnt = col_cnt + 1;
        if (col_cnt > COLUMNS) begin
            col_cnt = 0;
            row_idx = (row_idx + 1 > ROWS - 1) ? 0 : row_idx + 1;
            next_byte = CMD_SET_ADDR | ((row_idx != 0) ? ROW_OFFSET : 8'h00);
            next_rs   = 1'b0;
        end else begin
            next_byte = shown_char(col_cnt - 1 + COLUMNS * row_idx);
            next_rs   = 1'b1;
        end
    endtask

    task automatic step_bus(output t_out_word levels);
        case (bus_phase)
            PH_HIGH_SETUP: begin
                pins.reg_select  = next_rs;
                pins.enable      = 1'b0;
                pins.data_nibble = next_byte[7:4];
                bus_phase        = PH_HIGH_STROBE;
            end
            PH_HIGH_STROBE: begin
                pins.enable = 1'b1;
                bus_phase   = PH_LOW_SETUP;
            end
            PH_LOW_SETUP: begin
                pins.enable      = 1'b0;
                pins.data_nibble = next_byte[3:0];
                bus_phase        = PH_LOW_STROBE;
            end
            default: begin
                pins.enable = 1'b1;
                stage_next_byte();
                bus_phase = PH_HIGH_SETUP;
            end
        endcase
        levels = pins;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        int        delta;
        delta = 0;
        if (!i_rst_n) begin
            bus_phase = PH_HIGH_SETUP;
            col_cnt   = 0;
            row_idx   = 0;
            next_rs   = 1'b0;
            next_byte = CMD_SET_ADDR;
            pins      = '0;
            for (int i = 0; i < BUF_DEPTH; i++) begin
                shadow_buf[i] = '0;
            end
            pin_queue.delete();
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pin_queue.size() == 0) begin
                    $error("pin word with nothing expected: rs=%0d e=%0d nib=%h",
                           i_out_word.reg_select, i_out_word.enable,
                           i_out_word.data_nibble);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want  = pin_queue.pop_front();
                    delta = delta - 1;
                    o_checked_words = o_checked_words + 1;
                    if (i_out_word.reg_select !== want.reg_select) begin
                        $error("reg_select: expected %0d, got %0d",
                               want.reg_select, i_out_word.reg_select);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_word.enable !== want.enable) begin
                        $error("enable: expected %0d, got %0d",
                               want.enable, i_out_word.enable);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_word.data_nibble !== want.data_nibble) begin
                        $error("data_nibble: expected %h, got %h",
                               want.data_nibble, i_out_word.data_nibble);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_word.op == OP_WRITE) begin
                    shadow_buf[i_in_word.position] = i_in_word.character;
                    o_store_words = o_store_words + 1;
                end else begin
                    step_bus(want);
                    pin_queue.push_back(want);
                    delta = delta + 1;
                    o_tick_words = o_tick_words + 1;
                end
            end
            o_outstanding <= o_outstanding + delta;
        end
    end

endmodule

### dv/char_lcd_refresh_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_refresh_engine_tb
// Drives store and tick words into the LCD refresh engine with random gaps
// and output stalls, including a long receiver hold-off and a full drain.
// A checker beside the block predicts every pin word; this top reports.
// ----------------------------------------------------------------------------
module char_lcd_refresh_engine_tb;
    import clre_pkg::*;

    localparam int unsigned COLUMNS   = 16;
    localparam int unsigned ROWS      = 2;
    localparam int          N_RANDOM  = 650;
    localparam int          BURST_LO  = 250;
    localparam int          BURST_HI  = 330;
    localparam int          PAUSE_AT  = 450;
    localparam int          HOLD_CYC  = 80;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    logic      hold_req  = 1'b0;
    int        fail_count;
    int        outstanding;
    int        tick_words;
    int        store_words;
    int        checked_words;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    char_lcd_refresh_engine #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    char_lcd_refresh_engine_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_word      (in_word),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_word     (out_word),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_tick_words   (tick_words),
        .o_store_words  (store_words),
        .o_checked_words(checked_words)
    );

    task automatic send_word(input logic op, input logic [POS_W-1:0] pos,
                             input logic [CHAR_W-1:0] ch, input int gap);
        t_in_word w;
        w.op        = op;
        w.position  = pos;
        w.character = ch;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
    endtask

    // receiver: random ready delay per word, calm stretches, one long hold-off
    initial begin
        int wait_n;
        bit held;
        held = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req && !held) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                held = 1;
            end
            wait_n = ((checked_words % 90) < 25) ? 0 : $urandom_range(0, 17);
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin
        int          gap;
        logic        op;
        logic [7:0]  ch;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: buffer extremes, zero char, stores between bus phases
        send_word(OP_TICK,  5'd0,  8'h00, 0);
        send_word(OP_WRITE, 5'd0,  8'hFF, 0);
        send_word(OP_TICK,  5'd31, 8'hFF, 0);
        send_word(OP_WRITE, 5'd31, 8'h41, 0);
        send_word(OP_TICK,  5'd0,  8'h00, 1);
        send_word(OP_TICK,  5'd0,  8'h00, 0);
        send_word(OP_WRITE, 5'd1,  8'h00, 0);
        send_word(OP_WRITE, 5'd16, 8'h80, 2);
        send_word(OP_WRITE, 5'd15, 8'h01, 0);
        for (int i = 0; i < 12; i++) begin
            send_word(OP_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                      (i % 3 == 0) ? 3 : 0);
        end
        send_word(OP_WRITE, 5'd0,  8'h00, 0);
        send_word(OP_WRITE, 5'd30, 8'h7E, 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == PAUSE_AT) begin
                in_valid <= 1'b0;
                wait_drained();
            end
            if (i == BURST_LO) begin
                hold_req <= 1'b1;
            end
            if (i >= BURST_LO && i < BURST_HI) begin
                gap = 0;
                op  = ($urandom_range(0, 9) == 0) ? OP_WRITE : OP_TICK;
            end else begin
                gap = ((i % 100) < 30) ? 0 : $urandom_range(0, 17);
                op  = ($urandom_range(0, 9) < 3) ? OP_WRITE : OP_TICK;
            end
            ch = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            send_word(op, 5'($urandom_range(0, 31)), ch, gap);
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run: %0d tick words and %0d store words, %0d pin words compared",
                 tick_words, store_words, checked_words);
        $display("About %0d full screen refresh passes on the bus",
                 tick_words / (4 * (COLUMNS + 1) * ROWS));
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $error("timeout with %0d pin words still expected", outstanding);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/clre_pkg.sv
rtl/clre_buffer.sv
rtl/clre_seq.sv
rtl/char_lcd_refresh_engine.sv
dv/char_lcd_refresh_engine_checker.sv
dv/char_lcd_refresh_engine_tb.sv
